[rtl/cssr_pkg.sv]
`timescale 1ns / 1ps

package cssr_pkg;

   localparam int LANES_DEF  = 8;
   localparam int B_ROWS_DEF = 1024;

   // request opcodes
   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_NZ    = 2'd1,
      OP_FLUSH = 2'd2
   } op_type;

   // register indexes on the csr channel
   typedef enum logic [1:0] {
      CSR_ALPHA    = 2'd0,
      CSR_BASE     = 2'd1,
      CSR_COL_BASE = 2'd2
   } csr_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_ACC,
      ST_EMIT
   } state_type;

endpackage

[rtl/cssr_ram.sv]
`timescale 1ns / 1ps

module cssr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/coo_spmm_segmented_row_reducer.sv]
// channel | direction | handshake        | transaction
// req_    | in        | valid / stall    | load B byte, nonzero or flush
// rsp_    | out       | valid / stall    | one additive update for C
// csr_    | in        | valid / ready    | register write (index, data)
//
// A load, an ignored op and a flush with nothing open do not stall req. A nonzero
// steps through B row read from the lane RAMs, lane multiply and accumulate.
// A row change or flush emits LANES updates, one per cycle unless rsp stalls.
// req_stall is high while an item is in flight. Reset is synchronous and
// closes any open row; the B tile is not cleared. csr_ready is always high.
`timescale 1ns / 1ps

module coo_spmm_segmented_row_reducer #(
   parameter int LANES  = cssr_pkg::LANES_DEF,
   parameter int B_ROWS = cssr_pkg::B_ROWS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_op,
   input  logic [15:0] req_row_index,
   input  logic [15:0] req_col_index,
   input  logic [2:0]  req_lane,
   input  logic signed [7:0] req_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_c_row,
   output logic [15:0] rsp_c_col,
   output logic signed [31:0] rsp_add_value,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wr_data
);
   import cssr_pkg::*;

   localparam int ADDR_W = $clog2(B_ROWS);
   localparam int LANE_W = (LANES > 1) ? $clog2(LANES) : 1;

   state_type state_ff, state_in;

   logic [31:0] alpha_ff;
   logic        base_ff;
   logic [15:0] col_base_ff;

   logic [31:0] scaled_ff, scaled_in;
   logic        bvalid_ff, bvalid_in;
   logic [15:0] row_ff, row_in;
   logic        row_neg_ff, row_neg_in;
   logic        load_pend_ff, load_pend_in;
   logic [15:0] open_row_ff, open_row_in;
   logic        open_valid_ff, open_valid_in;
   logic [LANE_W-1:0] lane_cnt_ff, lane_cnt_in;
   logic [31:0] prod_ff [LANES];
   logic [31:0] prod_in [LANES];
   logic [31:0] sums_ff [LANES];
   logic [31:0] sums_in [LANES];

   logic        req_acc;
   logic        rsp_acc;
   logic [15:0] col_adj;
   logic        col_ok;
   logic        lane_ok;
   logic        row_hit;
   logic [7:0]  rd_byte [LANES];

   assign req_acc = req_valid && !req_stall;
   assign rsp_acc = rsp_valid && !rsp_stall;
   assign csr_ready = 1'b1;

   assign col_adj = req_col_index - {15'd0, base_ff};
   assign col_ok  = !(base_ff && req_col_index == 16'd0) &&
                    ({1'b0, col_adj} < 17'(B_ROWS));
   assign lane_ok = {1'b0, req_lane} < 4'(LANES);

   // one byte-wide RAM per lane so a load writes one lane only
   for (genvar p = 0; p < LANES; p++) begin : g_lane
      cssr_ram #(
         .WIDTH (8),
         .DEPTH (B_ROWS)
      ) u_ram (
         .clock   (clock),
         .wr_en   (req_acc && req_op == OP_LOAD && col_ok && lane_ok &&
                   req_lane == 3'(p)),
         .wr_addr (col_adj[ADDR_W-1:0]),
         .wr_data (req_value),
         .rd_en   (req_acc && req_op == OP_NZ),
         .rd_addr (col_adj[ADDR_W-1:0]),
         .rd_data (rd_byte[p])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff    <= 32'd1;
         base_ff     <= 1'b0;
         col_base_ff <= 16'd0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ALPHA:    alpha_ff    <= csr_wr_data;
            CSR_BASE:     base_ff     <= csr_wr_data[0];
            CSR_COL_BASE: col_base_ff <= csr_wr_data[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         open_valid_ff <= 1'b0;
         lane_cnt_ff   <= '0;
      end else begin
         state_ff      <= state_in;
         open_valid_ff <= open_valid_in;
         lane_cnt_ff   <= lane_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      scaled_ff    <= scaled_in;
      bvalid_ff    <= bvalid_in;
      row_ff       <= row_in;
      row_neg_ff   <= row_neg_in;
      load_pend_ff <= load_pend_in;
      open_row_ff  <= open_row_in;
      prod_ff      <= prod_in;
      sums_ff      <= sums_in;
   end

   assign row_hit = open_valid_ff && !row_neg_ff && row_ff == open_row_ff;

   always_comb begin
      state_in      = state_ff;
      scaled_in     = scaled_ff;
      bvalid_in     = bvalid_ff;
      row_in        = row_ff;
      row_neg_in    = row_neg_ff;
      load_pend_in  = load_pend_ff;
      open_row_in   = open_row_ff;
      open_valid_in = open_valid_ff;
      lane_cnt_in   = lane_cnt_ff;
      prod_in       = prod_ff;
      sums_in       = sums_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_acc && alpha_ff != 32'd0) begin
               case (req_op)
                  OP_NZ: begin
                     scaled_in  = alpha_ff * {{24{req_value[7]}}, req_value};
                     bvalid_in  = col_ok;
                     row_in     = req_row_index - {15'd0, base_ff};
                     row_neg_in = base_ff && req_row_index == 16'd0;
                     state_in   = ST_READ;
                  end
                  OP_FLUSH: begin
                     if (open_valid_ff) begin
                        load_pend_in = 1'b0;
                        lane_cnt_in  = '0;
                        state_in     = ST_EMIT;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_READ: begin
            for (int p = 0; p < LANES; p++) begin
               prod_in[p] = bvalid_ff ?
                            scaled_ff * {{24{rd_byte[p][7]}}, rd_byte[p]} : 32'd0;
            end
            state_in = ST_ACC;
         end
         ST_ACC: begin
            if (row_hit) begin
               for (int p = 0; p < LANES; p++) begin
                  sums_in[p] = sums_ff[p] + prod_ff[p];
               end
               state_in = ST_IDLE;
            end else if (open_valid_ff) begin
               // close the open row first, a valid new row opens after the burst
               load_pend_in = !row_neg_ff;
               lane_cnt_in  = '0;
               state_in     = ST_EMIT;
            end else begin
               if (!row_neg_ff) begin
                  sums_in       = prod_ff;
                  open_row_in   = row_ff;
                  open_valid_in = 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (rsp_acc) begin
               lane_cnt_in = lane_cnt_ff + 1'b1;
               if (lane_cnt_ff == LANE_W'(LANES - 1)) begin
                  lane_cnt_in = '0;
                  state_in    = ST_IDLE;
                  if (load_pend_ff) begin
                     sums_in       = prod_ff;
                     open_row_in   = row_ff;
                     open_valid_in = 1'b1;
                  end else begin
                     for (int p = 0; p < LANES; p++) begin
                        sums_in[p] = 32'd0;
                     end
                     open_valid_in = 1'b0;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_stall     = state_ff != ST_IDLE;
   assign rsp_valid     = state_ff == ST_EMIT;
   assign rsp_c_row     = open_row_ff;
   assign rsp_c_col     = col_base_ff + 16'(lane_cnt_ff);
   assign rsp_add_value = sums_ff[lane_cnt_ff];
   assign rsp_last      = lane_cnt_ff == LANE_W'(LANES - 1);

endmodule

[rtl/cssr_checker.sv]
`timescale 1ns / 1ps

module cssr_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [1:0]  req_op,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [15:0] rsp_c_row,
   input logic [15:0] rsp_c_col,
   input logic [31:0] rsp_add_value,
   input logic        rsp_last
);
   import cssr_pkg::*;

   // a stalled update holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_c_row) &&
      $stable(rsp_c_col) && $stable(rsp_add_value) && $stable(rsp_last))
      else $error("stalled rsp transaction changed");

   // updates only go out while the input side is held off
   a_busy_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("rsp transaction while req side open");

   // a burst runs without gaps over consecutive columns of one row
   a_burst: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last |=> rsp_valid &&
      $stable(rsp_c_row) && rsp_c_col == 16'($past(rsp_c_col) + 16'd1))
      else $error("row burst broken");

   // the req side is open again in the cycle after a B load
   a_load_fast: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_op == OP_LOAD |=> !req_stall)
      else $error("load transaction held the req side");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("block busy after reset");

endmodule

bind coo_spmm_segmented_row_reducer cssr_checker u_cssr_checker (.*);
